### rtl/cartridge_bank_controller_five_top_macros.svh
// assertion macros for the cartridge bank controller
// expects i_clk and i_rst_n in the scope where a macro is used
`ifndef CARTRIDGE_BANK_CONTROLLER_FIVE_TOP_MACROS_SVH
`define CARTRIDGE_BANK_CONTROLLER_FIVE_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define CBC5_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);
`define CBC5_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) (prop)) else $error(msg);
`else
`define CBC5_ASSERT(lbl, prop, msg)
`define CBC5_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

### rtl/cbc5_pkg.sv
// shared types, widths and codes of the cartridge bank controller
// no dependencies
`timescale 1ns / 1ps

package cbc5_pkg;

    localparam int RAM_BANKS      = 16;
    localparam int RAM_BANK_BYTES = 8192;
    localparam int RAM_DEPTH      = RAM_BANKS * RAM_BANK_BYTES;
    localparam int RAM_AW         = $clog2(RAM_DEPTH);
    localparam int BANK_OFS_W     = $clog2(RAM_BANK_BYTES);
    localparam int ROM_WIN_SHIFT  = 14;

    localparam int KIND_W     = 2;
    localparam int ADDR_W     = 16;
    localparam int BYTE_W     = 8;
    localparam int ROM_BANK_W = 9;
    localparam int RAM_BANK_W = $clog2(RAM_BANKS);
    localparam int ROM_CNT_W  = 10;
    localparam int RAM_CNT_W  = 5;
    localparam int ROM_OFS_W  = 23;
    localparam int RAM_OFS_W  = 17;
    localparam int CFG_W      = 10;
    localparam int CFG_IDX_W  = 1;
    localparam int STEP_W     = $clog2(ROM_BANK_W);
    localparam int Q_DEPTH    = 2;
    localparam int Q_PTR_W    = $clog2(Q_DEPTH);
    localparam int Q_CNT_W    = $clog2(Q_DEPTH + 1);

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ROM_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_RAM_COUNT = 1'b1;

    // bus access kinds
    localparam logic [KIND_W-1:0] KIND_CTRL = 2'd0;
    localparam logic [KIND_W-1:0] KIND_RD   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_WR   = 2'd2;

    localparam logic [3:0]        RAM_ENA_KEY = 4'hA;
    localparam logic [BYTE_W-1:0] RD_DISABLED = 8'hFF;

    typedef logic [2:0] t_opcode;
    localparam t_opcode OP_ENABLE   = 3'd0;
    localparam t_opcode OP_ROM_LO   = 3'd1;
    localparam t_opcode OP_ROM_HI   = 3'd2;
    localparam t_opcode OP_RAM_BANK = 3'd3;
    localparam t_opcode OP_READ     = 3'd4;
    localparam t_opcode OP_WRITE    = 3'd5;
    localparam t_opcode OP_NONE     = 3'd6;

    typedef struct packed {
        t_opcode                 op;
        logic [BANK_OFS_W-1:0]   ofs;
        logic [BYTE_W-1:0]       value;
    } t_op;

    typedef struct packed {
        logic               empty;
        logic               full;
        logic [Q_CNT_W-1:0] count;
    } t_q_stat;

    typedef struct packed {
        logic                  start;
        logic [ROM_BANK_W-1:0] rom_sel;
        logic [ROM_CNT_W-1:0]  rom_div;
        logic [RAM_BANK_W-1:0] ram_sel;
        logic [RAM_CNT_W-1:0]  ram_div;
    } t_rem_req;

    typedef struct packed {
        logic                  done;
        logic [ROM_BANK_W-1:0] rom_rem;
        logic [RAM_BANK_W-1:0] ram_rem;
    } t_rem_rsp;

endpackage

### rtl/cbc5_if.sv
// request and response channel interfaces
// depends on cbc5_pkg
`timescale 1ns / 1ps

interface cbc5_req_if;
    logic                         valid;
    logic                         ready;
    logic [cbc5_pkg::KIND_W-1:0]  kind;
    logic [cbc5_pkg::ADDR_W-1:0]  addr;
    logic [cbc5_pkg::BYTE_W-1:0]  value;

    modport source (output valid, kind, addr, value, input ready);
    modport sink   (input valid, kind, addr, value, output ready);
endinterface

interface cbc5_rsp_if;
    logic                           valid;
    logic                           ready;
    logic [cbc5_pkg::BYTE_W-1:0]    read_data;
    logic [cbc5_pkg::ROM_OFS_W-1:0] rom_offset;
    logic [cbc5_pkg::RAM_OFS_W-1:0] ram_offset;
    logic                           ram_enabled;

    modport source (output valid, read_data, rom_offset, ram_offset, ram_enabled, input ready);
    modport sink   (input valid, read_data, rom_offset, ram_offset, ram_enabled, output ready);
endinterface

### rtl/cbc5_front.sv
// front end: takes bus requests and decodes them into queue entries
// depends on cbc5_pkg, cbc5_if
`timescale 1ns / 1ps

module cbc5_front (
    cbc5_req_if.sink           i_req,
    input  cbc5_pkg::t_q_stat  i_q_stat,
    output logic               o_push,
    output cbc5_pkg::t_op      o_op
);
    import cbc5_pkg::*;

    t_opcode w_op;

    always_comb begin
        case (i_req.kind)
            KIND_CTRL: begin
                case (i_req.addr[14:12]) inside
                    [3'd0:3'd1]: w_op = OP_ENABLE;
                    3'd2:        w_op = OP_ROM_LO;
                    3'd3:        w_op = OP_ROM_HI;
                    [3'd4:3'd5]: w_op = OP_RAM_BANK;
                    default:     w_op = OP_NONE;
                endcase
            end
            KIND_RD: w_op = OP_READ;
            KIND_WR: w_op = OP_WRITE;
            default: w_op = OP_NONE;
        endcase
    end

    assign i_req.ready = !i_q_stat.full;
    assign o_push      = i_req.valid && !i_q_stat.full;
    assign o_op.op     = w_op;
    assign o_op.ofs    = i_req.addr[BANK_OFS_W-1:0];
    assign o_op.value  = i_req.value;

endmodule

### rtl/cbc5_queue.sv
// two-entry queue of decoded requests between front and back end
// depends on cbc5_pkg
`timescale 1ns / 1ps

module cbc5_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  cbc5_pkg::t_op      i_op,
    input  logic               i_pop,
    output cbc5_pkg::t_op      o_op,
    output cbc5_pkg::t_q_stat  o_stat
);
    import cbc5_pkg::*;

    t_op                r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wptr;
    logic [Q_PTR_W-1:0] r_rptr;
    logic [Q_CNT_W-1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_op;
        end
    end

    assign o_op         = r_mem[r_rptr];
    assign o_stat.empty = (r_count == '0);
    assign o_stat.full  = (r_count == Q_CNT_W'(Q_DEPTH));
    assign o_stat.count = r_count;

endmodule

### rtl/cbc5_rem.sv
// bit-serial remainder unit for the rom and ram bank windows
// depends on cbc5_pkg
`timescale 1ns / 1ps

module cbc5_rem (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  cbc5_pkg::t_rem_req  i_req,
    output cbc5_pkg::t_rem_rsp  o_rsp
);
    import cbc5_pkg::*;

    logic                  r_busy;
    logic                  r_done;
    logic [STEP_W-1:0]     r_step;
    logic [ROM_BANK_W-1:0] r_rom_q;
    logic [ROM_BANK_W-1:0] r_rom_r;
    logic [ROM_CNT_W-1:0]  r_rom_d;
    logic [ROM_BANK_W-1:0] r_ram_q;
    logic [RAM_BANK_W-1:0] r_ram_r;
    logic [RAM_CNT_W-1:0]  r_ram_d;

    logic [ROM_BANK_W:0]   w_rom_t;
    logic [ROM_BANK_W-1:0] w_rom_n;
    logic [RAM_BANK_W:0]   w_ram_t;
    logic [RAM_BANK_W-1:0] w_ram_n;

    // one restoring step per cycle on each lane while busy
    always_comb begin
        w_rom_t = {r_rom_r, r_rom_q[ROM_BANK_W-1]};
        w_ram_t = {r_ram_r, r_ram_q[ROM_BANK_W-1]};
        if (w_rom_t >= r_rom_d) begin
            w_rom_n = ROM_BANK_W'(w_rom_t - r_rom_d);
        end else begin
            w_rom_n = w_rom_t[ROM_BANK_W-1:0];
        end
        if (w_ram_t >= r_ram_d) begin
            w_ram_n = RAM_BANK_W'(w_ram_t - r_ram_d);
        end else begin
            w_ram_n = w_ram_t[RAM_BANK_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_step <= '0;
        end else if (r_busy) begin
            r_step <= r_step + 1'b1;
            if (r_step == STEP_W'(ROM_BANK_W - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rom_q <= i_req.rom_sel;
            r_rom_r <= '0;
            r_rom_d <= i_req.rom_div;
            r_ram_q <= {{(ROM_BANK_W-RAM_BANK_W){1'b0}}, i_req.ram_sel};
            r_ram_r <= '0;
            r_ram_d <= i_req.ram_div;
        end else if (r_busy) begin
            r_rom_q <= {r_rom_q[ROM_BANK_W-2:0], 1'b0};
            r_rom_r <= w_rom_n;
            r_ram_q <= {r_ram_q[ROM_BANK_W-2:0], 1'b0};
            r_ram_r <= w_ram_n;
        end
    end

    assign o_rsp.done    = r_done;
    assign o_rsp.rom_rem = r_rom_r;
    assign o_rsp.ram_rem = r_ram_r;

endmodule

### rtl/cbc5_back.sv
// back end: bank registers, banked ram, window offsets and response register
// depends on cbc5_pkg, cbc5_if
`timescale 1ns / 1ps

module cbc5_back (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [cbc5_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [cbc5_pkg::CFG_W-1:0]        i_cfg_data,
    input  cbc5_pkg::t_op                     i_q_op,
    input  cbc5_pkg::t_q_stat                 i_q_stat,
    output logic                              o_pop,
    output cbc5_pkg::t_rem_req                o_rem_req,
    input  cbc5_pkg::t_rem_rsp                i_rem_rsp,
    cbc5_rsp_if.source                        o_rsp
);
    import cbc5_pkg::*;

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_DIV_GO   = 3'd1;
    localparam logic [2:0] S_DIV_WAIT = 3'd2;
    localparam logic [2:0] S_EXEC     = 3'd3;
    localparam logic [2:0] S_RESP     = 3'd4;

    logic [2:0]            r_state;
    logic [2:0]            n_state;
    logic [ROM_CNT_W-1:0]  r_rom_cnt;
    logic [RAM_CNT_W-1:0]  r_ram_cnt;
    logic [ROM_BANK_W-1:0] r_rom_sel;
    logic [RAM_BANK_W-1:0] r_ram_sel;
    logic                  r_ram_en;
    logic                  r_dirty;
    logic [ROM_BANK_W-1:0] r_rom_rem;
    logic [RAM_BANK_W-1:0] r_ram_rem;
    t_op                   r_op;
    logic [BYTE_W-1:0]     r_rd_q;
    logic [BYTE_W-1:0]     r_mem [RAM_DEPTH];

    logic                  r_out_valid;
    logic [BYTE_W-1:0]     r_out_rd;
    logic [ROM_OFS_W-1:0]  r_out_rom;
    logic [RAM_OFS_W-1:0]  r_out_ram;
    logic                  r_out_en;

    logic                  w_bank_op;
    logic                  w_out_free;
    logic [RAM_AW-1:0]     w_idx;

    assign w_bank_op  = (i_q_op.op == OP_ROM_LO) || (i_q_op.op == OP_ROM_HI)
                     || (i_q_op.op == OP_RAM_BANK);
    assign w_out_free = !r_out_valid || o_rsp.ready;
    assign o_pop      = (r_state == S_IDLE) && !i_q_stat.empty;
    assign w_idx      = {r_ram_rem, r_op.ofs};

    always_comb begin
        case (r_state)
            S_IDLE: begin
                if (i_q_stat.empty) begin
                    n_state = S_IDLE;
                end else if (r_dirty || w_bank_op) begin
                    n_state = S_DIV_GO;
                end else begin
                    n_state = S_EXEC;
                end
            end
            S_DIV_GO:   n_state = S_DIV_WAIT;
            S_DIV_WAIT: n_state = i_rem_rsp.done ? S_EXEC : S_DIV_WAIT;
            S_EXEC:     n_state = S_RESP;
            S_RESP:     n_state = w_out_free ? S_IDLE : S_RESP;
            default:    n_state = S_IDLE;
        endcase
    end

    // zero counts act as one, ram count is clipped to the store
    always_comb begin
        o_rem_req.start   = (r_state == S_DIV_GO);
        o_rem_req.rom_sel = r_rom_sel;
        o_rem_req.ram_sel = r_ram_sel;
        if (r_rom_cnt == '0) begin
            o_rem_req.rom_div = ROM_CNT_W'(1);
        end else begin
            o_rem_req.rom_div = r_rom_cnt;
        end
        if (r_ram_cnt == '0) begin
            o_rem_req.ram_div = RAM_CNT_W'(1);
        end else if (r_ram_cnt > RAM_CNT_W'(RAM_BANKS)) begin
            o_rem_req.ram_div = RAM_CNT_W'(RAM_BANKS);
        end else begin
            o_rem_req.ram_div = r_ram_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_rom_cnt   <= ROM_CNT_W'(2);
            r_ram_cnt   <= RAM_CNT_W'(1);
            r_rom_sel   <= '0;
            r_ram_sel   <= '0;
            r_ram_en    <= 1'b0;
            r_dirty     <= 1'b0;
            r_rom_rem   <= '0;
            r_ram_rem   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;

            if (o_pop) begin
                case (i_q_op.op)
                    OP_ENABLE:   r_ram_en <= (i_q_op.value[3:0] == RAM_ENA_KEY);
                    OP_ROM_LO:   r_rom_sel[7:0] <= i_q_op.value;
                    OP_ROM_HI:   r_rom_sel[8] <= i_q_op.value[0];
                    OP_RAM_BANK: r_ram_sel <= i_q_op.value[RAM_BANK_W-1:0];
                    default:     ;
                endcase
                if (w_bank_op) begin
                    r_dirty <= 1'b1;
                end
            end

            if ((r_state == S_DIV_WAIT) && i_rem_rsp.done) begin
                r_rom_rem <= i_rem_rsp.rom_rem;
                r_ram_rem <= i_rem_rsp.ram_rem;
                r_dirty   <= 1'b0;
            end

            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_ROM_COUNT: r_rom_cnt <= i_cfg_data;
                    CFG_RAM_COUNT: r_ram_cnt <= i_cfg_data[RAM_CNT_W-1:0];
                    default:       ;
                endcase
                r_dirty <= 1'b1;
            end

            if ((r_state == S_RESP) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_op <= i_q_op;
        end
        if ((r_state == S_RESP) && w_out_free) begin
            if (r_op.op == OP_READ) begin
                r_out_rd <= r_ram_en ? r_rd_q : RD_DISABLED;
            end else begin
                r_out_rd <= '0;
            end
            r_out_rom <= {r_rom_rem, {ROM_WIN_SHIFT{1'b0}}};
            r_out_ram <= {r_ram_rem, {BANK_OFS_W{1'b0}}};
            r_out_en  <= r_ram_en;
        end
    end

    // banked ram, one access per request
    always_ff @(posedge i_clk) begin
        if (r_state == S_EXEC) begin
            if ((r_op.op == OP_WRITE) && r_ram_en) begin
                r_mem[w_idx] <= r_op.value;
            end
            r_rd_q <= r_mem[w_idx];
        end
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.read_data   = r_out_rd;
    assign o_rsp.rom_offset  = r_out_rom;
    assign o_rsp.ram_offset  = r_out_ram;
    assign o_rsp.ram_enabled = r_out_en;

endmodule

### rtl/cartridge_bank_controller_five_top.sv
// Cartridge bank controller of the fifth kind. Each bus request (control write, external ram
// read or external ram write) yields one response with the read byte and the rom and ram
// window offsets as they stand after the request. A front end decodes requests into a
// two-entry queue; the back end runs one request at a time. A ram read or write, or an
// ignored control write, goes through pop, ram access and response load. A request that
// writes a bank register, or the first request after a configuration write, reruns the
// bit-serial remainder unit for both windows: 9 steps plus start and capture. The queue
// keeps accepting until full while the back end is busy, and a finished response waits in
// the output register. The banked ram (16 banks of 8 KiB) has no reset contents; reading a
// byte that was never written gives an undefined value.
// depends on cbc5_pkg, cbc5_if, cbc5_front, cbc5_queue, cbc5_rem, cbc5_back and the macros header
`timescale 1ns / 1ps
`include "cartridge_bank_controller_five_top_macros.svh"

module cartridge_bank_controller_five_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    cbc5_req_if.sink                       i_req,
    cbc5_rsp_if.source                     o_rsp,
    // configuration writes, the user must write only while idle; the block does not enforce it
    input  logic                           i_cfg_we,
    input  logic [cbc5_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [cbc5_pkg::CFG_W-1:0]     i_cfg_data
);
    import cbc5_pkg::*;

    // queue handshake between the two halves
    logic     w_push;
    logic     w_pop;
    t_op      w_push_op;
    t_op      w_q_op;
    t_q_stat  w_q_stat;

    // remainder unit request and result
    t_rem_req w_rem_req;
    t_rem_rsp w_rem_rsp;

    // decode of incoming requests
    cbc5_front u_front (
        .i_req    (i_req),
        .i_q_stat (w_q_stat),
        .o_push   (w_push),
        .o_op     (w_push_op)
    );

    // lets the front accept while the back end is busy
    cbc5_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_op    (w_push_op),
        .i_pop   (w_pop),
        .o_op    (w_q_op),
        .o_stat  (w_q_stat)
    );

    // window offsets: bank mod effective count, one bit per cycle while busy
    cbc5_rem u_rem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_rem_req),
        .o_rsp   (w_rem_rsp)
    );

    // bank state, ram and response register
    cbc5_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_q_op     (w_q_op),
        .i_q_stat   (w_q_stat),
        .o_pop      (w_pop),
        .o_rem_req  (w_rem_req),
        .i_rem_rsp  (w_rem_rsp),
        .o_rsp      (o_rsp)
    );

    // every accepted request lands in the queue
    `CBC5_ASSERT(a_accept_push, i_req.valid && i_req.ready |-> w_push, "accepted request not queued")
    // the back end never pops an empty queue
    `CBC5_ASSERT(a_pop_nonempty, w_pop |-> !w_q_stat.empty, "pop from empty queue")
    // fill level tracks a lone push
    `CBC5_ASSERT(a_q_count_up, w_push && !w_pop |=> w_q_stat.count == $past(w_q_stat.count) + 2'd1, "queue count lost a push")
    // a start of the remainder unit clears its done flag
    `CBC5_ASSERT(a_rem_start_idle, w_rem_req.start |=> !w_rem_rsp.done, "remainder done right after start")

endmodule
